@@ sv/mcb_pkg.sv @@
// ----------------------------------------------------------------------------
// mcb_pkg
// Shared types and constants for the multi-click button detector.
// ----------------------------------------------------------------------------
package mcb_pkg;

   localparam int TIME_BITS  = 32;
   localparam int TO_BITS    = 16;
   localparam int TALLY_BITS = 7;
   localparam int CLICK_BITS = 8;
   localparam int CSR_BITS   = 2;

   localparam logic [TO_BITS-1:0]    SHORT_TO_RESET = 16'd250;
   localparam logic [TO_BITS-1:0]    LONG_TO_RESET  = 16'd1000;
   localparam logic [TALLY_BITS-1:0] TALLY_MAX      = 7'd127;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_SHORT_TIMEOUT = 2'd0,
      CSR_LONG_TIMEOUT  = 2'd1,
      CSR_SAMPLE_PAUSE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                        last_level;
      logic [TIME_BITS-1:0]        edge_time;
      logic [TALLY_BITS-1:0]       click_tally;
      logic                        pending_flag;
      logic signed [CLICK_BITS-1:0] reported_clicks;
      logic                        repeat_mode;
   } mcb_state_type;

   typedef struct packed {
      logic [TO_BITS-1:0] short_timeout_ms;
      logic [TO_BITS-1:0] long_timeout_ms;
      logic               sampling_paused;
   } mcb_cfg_type;

   typedef struct packed {
      logic                 pressed;
      logic [TIME_BITS-1:0] now_ms;
      logic                 ack_event;
      logic                 start_repeat;
      logic                 stop_repeat;
   } mcb_sample_type;

   typedef struct packed {
      logic                         event_pending;
      logic signed [CLICK_BITS-1:0] click_report;
      logic                         repeat_active;
   } mcb_result_type;

endpackage

@@ sv/mcb_step.sv @@
// ----------------------------------------------------------------------------
// mcb_step
// Next-state and result logic for one button sample.
// ----------------------------------------------------------------------------
module mcb_step (
   input  mcb_pkg::mcb_state_type  state,
   input  mcb_pkg::mcb_cfg_type    cfg,
   input  mcb_pkg::mcb_sample_type smp,
   output mcb_pkg::mcb_state_type  state_next,
   output mcb_pkg::mcb_result_type result
);
   import mcb_pkg::*;

   logic [TIME_BITS-1:0] elapsed_raw;
   logic [TIME_BITS-1:0] elapsed;
   logic                 edge_seen;

   assign elapsed_raw = smp.now_ms - state.edge_time;

   always_comb begin
      mcb_state_type s;
      s         = state;
      edge_seen = 1'b0;
      elapsed   = '0;

      if (smp.stop_repeat && s.repeat_mode) begin
         s.repeat_mode  = 1'b0;
         s.click_tally  = '0;
         s.last_level   = 1'b1;
         s.pending_flag = 1'b0;
      end
      if (smp.start_repeat) begin
         s.repeat_mode = 1'b1;
         s.last_level  = 1'b0;
      end

      if (!cfg.sampling_paused) begin
         if (s.repeat_mode && !smp.pressed) begin
            s.repeat_mode = 1'b0;
            s.click_tally = '0;
         end
         if (smp.pressed != s.last_level) begin
            if (smp.pressed && (s.click_tally < TALLY_MAX)) begin
               s.click_tally = s.click_tally + 1'b1;
            end
            s.edge_time  = smp.now_ms;
            s.last_level = smp.pressed;
            edge_seen    = 1'b1;
         end else if (s.repeat_mode &&
                      (elapsed_raw > {{(TIME_BITS-TO_BITS){1'b0}}, cfg.long_timeout_ms})) begin
            s.last_level = 1'b0;
         end
         elapsed = edge_seen ? '0 : elapsed_raw;
         if (!s.pending_flag && !s.repeat_mode && !smp.pressed &&
             (elapsed > {{(TIME_BITS-TO_BITS){1'b0}}, cfg.short_timeout_ms})) begin
            s.reported_clicks = {1'b0, s.click_tally};
            if (s.click_tally != '0) begin
               s.pending_flag = 1'b1;
               s.click_tally  = '0;
            end
         end
         if (!s.pending_flag && smp.pressed &&
             (elapsed > {{(TIME_BITS-TO_BITS){1'b0}}, cfg.long_timeout_ms})) begin
            s.reported_clicks = -$signed({1'b0, s.click_tally});
            if (s.click_tally != '0) begin
               s.pending_flag = 1'b1;
               s.click_tally  = '0;
            end
         end
      end

      result.event_pending = s.pending_flag;
      result.click_report  = s.reported_clicks;
      result.repeat_active = s.repeat_mode;

      if (smp.ack_event) begin
         s.pending_flag = 1'b0;
      end
      state_next = s;
   end

endmodule

@@ sv/multi_click_button_detector_top.sv @@
// ----------------------------------------------------------------------------
// multi_click_button_detector_top
// Multi-click and long-press detector for one debounced button.
// ----------------------------------------------------------------------------
// Each item is one button sample with a millisecond time stamp and gives one
// result. A sample is captured in an input register, processed combinationally
// against the detector state, and the result is held in an output register, so
// the block takes one item per cycle while the result side keeps up. The user
// must write timeouts and the pause flag through the csr port only while the
// block is idle; the block itself does not enforce this.
module multi_click_button_detector_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_pressed,
   input  logic [mcb_pkg::TIME_BITS-1:0]      req_now_ms,
   input  logic                               req_ack_event,
   input  logic                               req_start_repeat,
   input  logic                               req_stop_repeat,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_event_pending,
   output logic signed [mcb_pkg::CLICK_BITS-1:0] rsp_click_report,
   output logic                               rsp_repeat_active,
   input  logic                               csr_we,
   input  logic [mcb_pkg::CSR_BITS-1:0]       csr_index,
   input  logic [mcb_pkg::TO_BITS-1:0]        csr_wdata
);
   import mcb_pkg::*;

   mcb_cfg_type    cfg_ff;
   mcb_state_type  state_ff;
   mcb_state_type  state_in;
   mcb_sample_type smp_ff;
   logic           smp_valid_ff;
   mcb_result_type result_in;
   mcb_result_type result_ff;
   logic           rsp_valid_ff;
   logic           advance;

   assign advance   = smp_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !smp_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_timeout_ms <= SHORT_TO_RESET;
         cfg_ff.long_timeout_ms  <= LONG_TO_RESET;
         cfg_ff.sampling_paused  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SHORT_TIMEOUT: cfg_ff.short_timeout_ms <= csr_wdata;
            CSR_LONG_TIMEOUT:  cfg_ff.long_timeout_ms  <= csr_wdata;
            CSR_SAMPLE_PAUSE:  cfg_ff.sampling_paused  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         smp_ff.pressed      <= req_pressed;
         smp_ff.now_ms       <= req_now_ms;
         smp_ff.ack_event    <= req_ack_event;
         smp_ff.start_repeat <= req_start_repeat;
         smp_ff.stop_repeat  <= req_stop_repeat;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            smp_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   mcb_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .smp        (smp_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_pending = result_ff.event_pending;
   assign rsp_click_report  = result_ff.click_report;
   assign rsp_repeat_active = result_ff.repeat_active;

`ifndef SYNTHESIS
   a_pending_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.pending_flag |-> (state_ff.reported_clicks != '0))
      else $error("pending flag set with a zero click report");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("detector state changed without an item");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !smp_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-click button detector.
// ----------------------------------------------------------------------------
// Button samples are sent through the request channel while the result channel
// is drained with random back-pressure. A behavioral copy of the detector,
// updated on every accepted item and every register write, predicts each
// result, and results are compared field by field in order. A short table of
// hand-checked samples comes first, followed by random click bursts, held
// repeat sequences and noise under several timeout settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mcb_pkg::*;

   typedef struct {
      bit                           cfg_write;
      logic [TO_BITS-1:0]           short_ms;
      logic [TO_BITS-1:0]           long_ms;
      logic                         paused;
      logic                         pressed;
      logic [TIME_BITS-1:0]         now_ms;
      logic                         ack;
      logic                         start;
      logic                         stop;
      bit                           typed;
      logic                         pending;
      logic signed [CLICK_BITS-1:0] report;
      logic                         active;
   } dir_row_type;

   typedef struct {
      bit             typed;
      mcb_result_type want;
   } typed_check_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_pressed = 1'b0;
   logic [TIME_BITS-1:0]         req_now_ms = '0;
   logic                         req_ack_event = 1'b0;
   logic                         req_start_repeat = 1'b0;
   logic                         req_stop_repeat = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_event_pending;
   logic signed [CLICK_BITS-1:0] rsp_click_report;
   logic                         rsp_repeat_active;
   logic                         csr_we = 1'b0;
   csr_index_type                csr_index = CSR_SHORT_TIMEOUT;
   logic [TO_BITS-1:0]           csr_wdata = '0;

   mcb_state_type        btn;
   mcb_cfg_type          settings;
   mcb_result_type       expected_reports [$];
   typed_check_type      typed_checks [$];
   int                   mismatches = 0;
   int                   samples_sent = 0;
   int                   idle_pct = 0;
   int                   stall_pct = 0;
   int                   rsp_hold_cycles = 0;
   logic [TIME_BITS-1:0] stamp_ms = '0;
   logic [TO_BITS-1:0]   cur_short = SHORT_TO_RESET;
   logic [TO_BITS-1:0]   cur_long = LONG_TO_RESET;

   dir_row_type dir_table [25] = '{
      '{0, 0, 0, 0,     0, 0, 0, 0, 0,                1, 0, 0, 0},
      '{0, 0, 0, 0,     1, 10, 0, 0, 0,               1, 0, 0, 0},
      '{0, 0, 0, 0,     0, 50, 0, 0, 0,               1, 0, 0, 0},
      '{0, 0, 0, 0,     1, 100, 0, 0, 0,              1, 0, 0, 0},
      '{0, 0, 0, 0,     0, 150, 0, 0, 0,              1, 0, 0, 0},
      '{0, 0, 0, 0,     0, 401, 1, 0, 0,              1, 1, 2, 0},
      '{0, 0, 0, 0,     0, 700, 0, 0, 0,              1, 0, 0, 0},
      '{0, 0, 0, 0,     1, 800, 0, 0, 0,              1, 0, 0, 0},
      '{0, 0, 0, 0,     1, 1801, 0, 0, 0,             1, 1, -1, 0},
      '{0, 0, 0, 0,     1, 3000, 1, 0, 0,             1, 1, -1, 0},
      '{0, 0, 0, 0,     0, 3100, 0, 1, 0,             1, 0, 0, 0},
      '{0, 0, 0, 0,     1, 3200, 0, 1, 0,             1, 0, 0, 1},
      '{0, 0, 0, 0,     1, 4201, 1, 0, 0,             1, 1, -1, 1},
      '{0, 0, 0, 0,     1, 4202, 0, 0, 0,             1, 0, -1, 1},
      '{0, 0, 0, 0,     1, 4300, 0, 0, 1,             1, 0, -1, 0},
      '{0, 0, 0, 0,     1, 4400, 0, 1, 1,             1, 0, -1, 1},
      '{0, 0, 0, 0,     1, 4410, 0, 1, 1,             1, 0, -1, 1},
      '{0, 0, 0, 0,     0, 4500, 0, 0, 0,             1, 0, -1, 0},
      '{1, 0, 0, 0,     0, 32'hFFFF_FFF0, 0, 0, 0,    0, 0, 0, 0},
      '{0, 0, 0, 0,     1, 32'hFFFF_FFFF, 0, 0, 0,    0, 0, 0, 0},
      '{0, 0, 0, 0,     1, 0, 1, 0, 0,                0, 0, 0, 0},
      '{0, 0, 0, 0,     0, 0, 1, 0, 0,                0, 0, 0, 0},
      '{1, 65535, 65535, 1, 1, 32'h8000_0000, 1, 1, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0,     0, 32'h7FFF_FFFF, 1, 0, 1,    0, 0, 0, 0},
      '{1, 250, 1000, 0, 1, 32'h8000_0001, 0, 0, 0,   0, 0, 0, 0}
   };

   multi_click_button_detector_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pressed       (req_pressed),
      .req_now_ms        (req_now_ms),
      .req_ack_event     (req_ack_event),
      .req_start_repeat  (req_start_repeat),
      .req_stop_repeat   (req_stop_repeat),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_pending (rsp_event_pending),
      .rsp_click_report  (rsp_click_report),
      .rsp_repeat_active (rsp_repeat_active),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit chance(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic logic [TIME_BITS-1:0] span_ms(input logic [TO_BITS-1:0] limit,
                                                    input bit past);
      if (past)
         return TIME_BITS'(limit) + 1 + (chance(25) ? 0 : $urandom_range(400));
      return chance(15) ? TIME_BITS'(limit) : $urandom_range(TIME_BITS'(limit), 0);
   endfunction

   function automatic mcb_result_type next_report(input mcb_sample_type smp);
      mcb_result_type res;
      if (smp.stop_repeat && btn.repeat_mode) begin
         btn.repeat_mode  = 1'b0;
         btn.click_tally  = '0;
         btn.last_level   = 1'b1;
         btn.pending_flag = 1'b0;
      end
      if (smp.start_repeat) begin
         btn.repeat_mode = 1'b1;
         btn.last_level  = 1'b0;
      end
      if (!settings.sampling_paused) begin
         if (btn.repeat_mode && !smp.pressed) begin
            btn.repeat_mode = 1'b0;
            btn.click_tally = '0;
         end
         if (smp.pressed != btn.last_level) begin
            if (smp.pressed && btn.click_tally != TALLY_MAX)
               btn.click_tally = btn.click_tally + 1'b1;
            btn.edge_time  = smp.now_ms;
            btn.last_level = smp.pressed;
         end else if (btn.repeat_mode &&
                      (smp.now_ms - btn.edge_time) > TIME_BITS'(settings.long_timeout_ms)) begin
            btn.last_level = 1'b0;
         end
         if (!btn.pending_flag && !btn.repeat_mode && !smp.pressed &&
             (smp.now_ms - btn.edge_time) > TIME_BITS'(settings.short_timeout_ms)) begin
            btn.reported_clicks = {1'b0, btn.click_tally};
            if (btn.click_tally != 0) begin
               btn.pending_flag = 1'b1;
               btn.click_tally  = '0;
            end
         end
         if (!btn.pending_flag && smp.pressed &&
             (smp.now_ms - btn.edge_time) > TIME_BITS'(settings.long_timeout_ms)) begin
            btn.reported_clicks = -$signed({1'b0, btn.click_tally});
            if (btn.click_tally != 0) begin
               btn.pending_flag = 1'b1;
               btn.click_tally  = '0;
            end
         end
      end
      res.event_pending = btn.pending_flag;
      res.click_report  = btn.reported_clicks;
      res.repeat_active = btn.repeat_mode;
      if (smp.ack_event)
         btn.pending_flag = 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin : scoreboard
      mcb_sample_type  smp;
      mcb_result_type  want;
      typed_check_type tc;
      if (reset) begin
         btn      = '0;
         settings = '{SHORT_TO_RESET, LONG_TO_RESET, 1'b0};
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SHORT_TIMEOUT: settings.short_timeout_ms = csr_wdata;
               CSR_LONG_TIMEOUT:  settings.long_timeout_ms = csr_wdata;
               CSR_SAMPLE_PAUSE:  settings.sampling_paused = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready === 1'b1) begin
            smp  = '{req_pressed, req_now_ms, req_ack_event, req_start_repeat,
                     req_stop_repeat};
            want = next_report(smp);
            if (typed_checks.size() != 0) begin
               tc = typed_checks.pop_front();
               if (tc.typed)
                  want = tc.want;
            end
            expected_reports.push_back(want);
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("result item arrived with no expectation waiting");
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_event_pending !== want.event_pending) begin
                  $error("event_pending: expected %0d, got %0d",
                         want.event_pending, rsp_event_pending);
                  mismatches++;
               end
               if (rsp_click_report !== want.click_report) begin
                  $error("click_report: expected %0d, got %0d",
                         want.click_report, rsp_click_report);
                  mismatches++;
               end
               if (rsp_repeat_active !== want.repeat_active) begin
                  $error("repeat_active: expected %0d, got %0d",
                         want.repeat_active, rsp_repeat_active);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin : rsp_pacing
      int stretch;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            stretch = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (stretch) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic offer_sample(input logic pressed, input logic [TIME_BITS-1:0] now_ms,
                               input logic ack, input logic start, input logic stop);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pressed      <= pressed;
      req_now_ms       <= now_ms;
      req_ack_event    <= ack;
      req_start_repeat <= start;
      req_stop_repeat  <= stop;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      samples_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic [TO_BITS-1:0] short_ms,
                                 input logic [TO_BITS-1:0] long_ms, input logic paused);
      csr_we    <= 1'b1;
      csr_index <= CSR_SHORT_TIMEOUT;
      csr_wdata <= short_ms;
      @(posedge clock);
      csr_index <= CSR_LONG_TIMEOUT;
      csr_wdata <= long_ms;
      @(posedge clock);
      csr_index <= CSR_SAMPLE_PAUSE;
      csr_wdata <= TO_BITS'(paused);
      @(posedge clock);
      csr_we <= 1'b0;
      cur_short = short_ms;
      cur_long  = long_ms;
   endtask

   task automatic click_burst();
      int clicks;
      clicks = chance(5) ? $urandom_range(135, 120) : $urandom_range(4, 1);
      repeat (clicks) begin
         stamp_ms += span_ms(cur_short, 1'b0);
         offer_sample(1'b1, stamp_ms, chance(30), 1'b0, 1'b0);
         if (clicks < 8 && chance(30)) begin
            stamp_ms += span_ms(cur_long >> 1, 1'b0);
            offer_sample(1'b1, stamp_ms, chance(30), 1'b0, 1'b0);
            stamp_ms += span_ms(cur_long >> 1, 1'b0);
         end else begin
            stamp_ms += span_ms(cur_long, 1'b0);
         end
         offer_sample(1'b0, stamp_ms, chance(30), 1'b0, 1'b0);
      end
      if (chance(50)) begin
         stamp_ms += span_ms(cur_short, 1'b1);
         offer_sample(1'b0, stamp_ms, chance(50), 1'b0, 1'b0);
      end else begin
         stamp_ms += span_ms(cur_short, 1'b0);
         offer_sample(1'b1, stamp_ms, chance(20), 1'b0, 1'b0);
         stamp_ms += span_ms(cur_long, 1'b1);
         offer_sample(1'b1, stamp_ms, chance(50), 1'b0, 1'b0);
         stamp_ms += span_ms(cur_short, 1'b0);
         offer_sample(1'b0, stamp_ms, chance(50), 1'b0, 1'b0);
      end
   endtask

   task automatic repeat_hold();
      int laps;
      laps = $urandom_range(5, 1);
      stamp_ms += span_ms(cur_short, 1'b0);
      offer_sample(1'b1, stamp_ms, chance(30), 1'b1, 1'b0);
      repeat (laps) begin
         stamp_ms += span_ms(cur_long, chance(70));
         offer_sample(1'b1, stamp_ms, chance(60), chance(10), 1'b0);
      end
      stamp_ms += span_ms(cur_short, 1'b0);
      if (chance(50))
         offer_sample(1'b0, stamp_ms, chance(50), 1'b0, 1'b0);
      else
         offer_sample(chance(50), stamp_ms, chance(50), chance(30), 1'b1);
   endtask

   task automatic noise_sample();
      offer_sample(chance(50), chance(50) ? $urandom() : stamp_ms + $urandom_range(3),
                   chance(50), chance(25), chance(25));
   endtask

   initial begin
      logic [TO_BITS-1:0] short_ms;
      logic [TO_BITS-1:0] long_ms;
      logic               paused;
      int                 goal;
      int                 pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         if (dir_table[i].cfg_write) begin
            drain();
            write_settings(dir_table[i].short_ms, dir_table[i].long_ms, dir_table[i].paused);
         end
         typed_checks.push_back('{dir_table[i].typed, '{dir_table[i].pending,
                                 dir_table[i].report, dir_table[i].active}});
         offer_sample(dir_table[i].pressed, dir_table[i].now_ms, dir_table[i].ack,
                      dir_table[i].start, dir_table[i].stop);
      end

      for (int ph = 0; ph < 9; ph++) begin
         paused = 1'b0;
         case (ph)
            0: begin
               short_ms = SHORT_TO_RESET;
               long_ms  = LONG_TO_RESET;
            end
            1: begin
               short_ms = '0;
               long_ms  = '0;
            end
            2: begin
               short_ms = '1;
               long_ms  = '1;
            end
            3: begin
               short_ms = $urandom_range(600);
               long_ms  = $urandom_range(3000);
               paused   = 1'b1;
            end
            default: begin
               short_ms = $urandom_range(600);
               long_ms  = $urandom_range(3000);
            end
         endcase
         drain();
         write_settings(short_ms, long_ms, paused);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 56; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 56; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         if (ph == 4)
            rsp_hold_cycles = 300;
         goal     = samples_sent + (paused ? 50 : 130);
         stamp_ms = $urandom();
         while (samples_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 65)
               click_burst();
            else if (pick < 88)
               repeat_hold();
            else
               noise_sample();
         end
      end

      drain();
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #400us;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
